// File: rtl/fpa_pkg.sv
// Shared types, constants and helper functions for the fixed-point ALU.
// Used by every module of the block; depends on nothing else.
package fpa_pkg;

    localparam int DATA_W          = 64;
    localparam int FMT_W           = 7;
    localparam int FUNC_W          = 4;
    localparam int MSB_W           = $clog2(DATA_W);
    localparam int MAX_WIDTH_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int DIV_STEPS       = 2 * DATA_W;
    localparam int CNT_W           = $clog2(DIV_STEPS + 1);
    localparam int CFG_IDX_W       = 2;
    localparam int IN_TDATA_W      = 152;
    localparam int OUT_TDATA_W     = 72;

    localparam logic [FMT_W-1:0] RESET_TOTAL_WIDTH  = 7'd32;
    localparam logic [FMT_W-1:0] RESET_INTEGER_BITS = 7'd16;

    typedef enum logic [FUNC_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_REM  = 4'd4,
        OP_NEG  = 4'd5,
        OP_CONV = 4'd6,
        OP_FINT = 4'd7,
        OP_TINT = 4'd8,
        OP_CMP  = 4'd9
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_WIDTH  = 2'd0,
        CFG_INTEGER_BITS = 2'd1,
        CFG_SIGNED       = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] xa;
        logic [DATA_W-1:0] xb;
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic              na;
        logic              nb;
        logic              sgn;
        logic [DATA_W-1:0] mask;
        logic [MSB_W-1:0]  msb;
        logic [FMT_W-1:0]  frac;
        logic [FMT_W-1:0]  dfrac;
        logic [DATA_W-1:0] dmask;
    } item_t;

    function automatic logic [DATA_W-1:0] width_mask(input logic [FMT_W-1:0] w);
        return (DATA_W'(1) << w) - DATA_W'(1);
    endfunction

endpackage

// File: rtl/fpa_front.sv
// Front end: configuration registers, input beat register and operand decode.
// Depends on fpa_pkg.
module fpa_front
    import fpa_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [FMT_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                  item_valid,
    input  logic                  item_ready,
    output item_t                 item
);

    localparam logic [FMT_W-1:0] MAX_W = FMT_W'(MAX_WIDTH);

    logic [FMT_W-1:0]      total_width_reg;
    logic [FMT_W-1:0]      integer_bits_reg;
    logic                  signed_reg;
    logic                  in_valid_reg;
    logic [IN_TDATA_W-1:0] in_data_reg;

    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
    logic [FMT_W-1:0]  dw;
    logic [FMT_W-1:0]  di;
    logic [FMT_W-1:0]  w;
    logic [FMT_W-1:0]  ib;
    logic [FMT_W-1:0]  wd;
    logic [FMT_W-1:0]  id;
    logic [FMT_W-1:0]  wm1;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              sa;
    logic              sb;
    logic [DATA_W-1:0] xa;
    logic [DATA_W-1:0] xb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_width_reg  <= RESET_TOTAL_WIDTH;
            integer_bits_reg <= RESET_INTEGER_BITS;
            signed_reg       <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TOTAL_WIDTH:  total_width_reg  <= cfg_data;
                CFG_INTEGER_BITS: integer_bits_reg <= cfg_data;
                CFG_SIGNED:       signed_reg       <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign s_axis_tready = !in_valid_reg || item_ready;
    assign item_valid    = in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    always_comb
    begin
        func = in_data_reg[3:0];
        op_a = in_data_reg[67:4];
        op_b = in_data_reg[131:68];
        dw   = in_data_reg[138:132];
        di   = in_data_reg[145:139];

        if (total_width_reg < 7'd2)
            w = 7'd2;
        else if (total_width_reg > MAX_W)
            w = MAX_W;
        else
            w = total_width_reg;
        ib  = (integer_bits_reg > w) ? w : integer_bits_reg;
        wm1 = w - 7'd1;
        m   = width_mask(w);
        a   = op_a & m;
        b   = op_b & m;
        sa  = signed_reg && a[wm1[MSB_W-1:0]];
        sb  = signed_reg && b[wm1[MSB_W-1:0]];
        xa  = sa ? (a | ~m) : a;
        xb  = sb ? (b | ~m) : b;

        if (dw < 7'd1)
            wd = 7'd1;
        else if (dw > MAX_W)
            wd = MAX_W;
        else
            wd = dw;
        id = (di > wd) ? wd : di;

        item.func  = func;
        item.a     = a;
        item.b     = b;
        item.xa    = xa;
        item.xb    = xb;
        item.ma    = sa ? (DATA_W'(0) - xa) : a;
        item.mb    = sb ? (DATA_W'(0) - xb) : b;
        item.na    = sa;
        item.nb    = sb;
        item.sgn   = signed_reg;
        item.mask  = m;
        item.msb   = wm1[MSB_W-1:0];
        item.frac  = w - ib;
        item.dfrac = wd - id;
        item.dmask = width_mask(wd);
    end

endmodule

// File: rtl/fpa_queue.sv
// Short FIFO of decoded items between the front end and the execution pipeline.
// Depends on fpa_pkg.
module fpa_queue
    import fpa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    item_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_QW-1:0]  count_next;
    logic               do_wr;
    logic               do_rd;

    assign wr_ready = (count_reg != CNT_QW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg + CNT_QW'(do_wr) - CNT_QW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: rtl/fpa_back.sv
// Execution pipeline: partial products and restoring divider, result assembly,
// product narrowing, remainder fix-up and the output register. Depends on fpa_pkg.
module fpa_back
    import fpa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int HALF_W = DATA_W / 2;
    localparam int PROD_W = 2 * DATA_W;

    // Stage 1: partial products or divider iterations.
    logic              x1_valid_reg;
    item_t             x1_item_reg;
    logic [DATA_W-1:0] pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [PROD_W-1:0] num_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              dz1_reg;
    logic [PROD_W-1:0] num_next;
    logic [DATA_W-1:0] rem_next;
    logic [CNT_W-1:0]  cnt_next;

    // Stage 2: product and quotient assembled, simple results.
    logic              x2_valid_reg;
    item_t             x2_item_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DATA_W-1:0] n_reg;
    logic [DATA_W-1:0] res2_reg;
    logic              less2_reg, equal2_reg, dz2_reg;
    logic [PROD_W-1:0] prod_next;
    logic [DATA_W-1:0] n_next;
    logic [DATA_W-1:0] res2_next;
    logic              less2_next, equal2_next;

    // Stage 3: product narrowed, remainder partial products.
    logic              x3_valid_reg;
    item_t             x3_item_reg;
    logic [DATA_W-1:0] p0_reg;
    logic [HALF_W-1:0] pmid_reg;
    logic [DATA_W-1:0] res3_reg;
    logic              less3_reg, equal3_reg, dz3_reg;
    logic [DATA_W-1:0] p0_next;
    logic [HALF_W-1:0] pmid_next;
    logic [DATA_W-1:0] res3_next;

    // Output register.
    logic              o_valid_reg;
    logic [DATA_W-1:0] res_reg;
    logic              less_reg, equal_reg, dz_reg;
    logic [DATA_W-1:0] res_next;

    logic              o_ready, x3_ready, x2_ready, x1_adv, load1, is_div_in;
    logic              div_take;
    logic [DATA_W-1:0] div_shift;
    logic [PROD_W-1:0] prod_mag, quo;
    logic [DATA_W-1:0] nm, qlo, z, z_fix;
    logic [DATA_W-1:0] ph0, ph1;
    logic              neg1, zn;
    logic [FMT_W-1:0]  d_up, d_dn;

    assign o_ready    = !o_valid_reg || m_axis_tready;
    assign x3_ready   = !x3_valid_reg || o_ready;
    assign x2_ready   = !x2_valid_reg || x3_ready;
    assign x1_adv     = x1_valid_reg && (cnt_reg == '0) && x2_ready;
    assign item_ready = !x1_valid_reg || x1_adv;
    assign load1      = item_valid && item_ready;
    assign is_div_in  = (item.func == OP_DIV) || (item.func == OP_REM);

    // Stage 1 next values: load a new item or run one divider step.
    always_comb
    begin
        div_shift = {rem_reg[DATA_W-2:0], num_reg[PROD_W-1]};
        div_take  = rem_reg[DATA_W-1] || (div_shift >= x1_item_reg.mb);
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (load1)
        begin
            num_next = {{DATA_W{1'b0}}, item.ma} << item.frac;
            rem_next = '0;
            cnt_next = (is_div_in && (item.mb != '0)) ? CNT_W'(DIV_STEPS) : '0;
        end
        else if (x1_valid_reg && (cnt_reg != '0))
        begin
            num_next = {num_reg[PROD_W-2:0], div_take};
            rem_next = div_take ? (div_shift - x1_item_reg.mb) : div_shift;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (item_ready)
                x1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (load1)
        begin
            x1_item_reg <= item;
            dz1_reg     <= is_div_in && (item.mb == '0);
            pp00_reg    <= item.ma[HALF_W-1:0] * item.mb[HALF_W-1:0];
            pp01_reg    <= item.ma[HALF_W-1:0] * item.mb[DATA_W-1:HALF_W];
            pp10_reg    <= item.ma[DATA_W-1:HALF_W] * item.mb[HALF_W-1:0];
            pp11_reg    <= item.ma[DATA_W-1:HALF_W] * item.mb[DATA_W-1:HALF_W];
        end
    end

    // Stage 2 next values.
    always_comb
    begin
        neg1     = x1_item_reg.na != x1_item_reg.nb;
        prod_mag = {{DATA_W{1'b0}}, pp00_reg}
                 + {{HALF_W{1'b0}}, pp01_reg, {HALF_W{1'b0}}}
                 + {{HALF_W{1'b0}}, pp10_reg, {HALF_W{1'b0}}}
                 + {pp11_reg, {DATA_W{1'b0}}};
        prod_next = neg1 ? (PROD_W'(0) - prod_mag) : prod_mag;
        quo       = (neg1 && (rem_reg != '0)) ? (num_reg + PROD_W'(1)) : num_reg;
        qlo       = quo[DATA_W-1:0];
        nm        = DATA_W'(quo >> x1_item_reg.frac);
        n_next    = neg1 ? (DATA_W'(0) - nm) : nm;
        d_up      = x1_item_reg.dfrac - x1_item_reg.frac;
        d_dn      = x1_item_reg.frac - x1_item_reg.dfrac;

        res2_next   = '0;
        less2_next  = 1'b0;
        equal2_next = 1'b0;
        case (x1_item_reg.func)
            OP_ADD:  res2_next = (x1_item_reg.a + x1_item_reg.b) & x1_item_reg.mask;
            OP_SUB:  res2_next = (x1_item_reg.a - x1_item_reg.b) & x1_item_reg.mask;
            OP_DIV:
            begin
                if (!dz1_reg)
                    res2_next = (neg1 ? (DATA_W'(0) - qlo) : qlo) & x1_item_reg.mask;
            end
            OP_NEG:  res2_next = (DATA_W'(0) - x1_item_reg.a) & x1_item_reg.mask;
            OP_CONV:
            begin
                if (x1_item_reg.dfrac > x1_item_reg.frac)
                    res2_next = x1_item_reg.xa << d_up;
                else if (x1_item_reg.sgn)
                    res2_next = DATA_W'($signed(x1_item_reg.xa) >>> d_dn);
                else
                    res2_next = x1_item_reg.xa >> d_dn;
                res2_next = res2_next & x1_item_reg.dmask;
            end
            OP_FINT: res2_next = (x1_item_reg.a << x1_item_reg.frac) & x1_item_reg.mask;
            OP_TINT:
            begin
                res2_next = x1_item_reg.ma >> x1_item_reg.frac;
                if (x1_item_reg.na)
                    res2_next = DATA_W'(0) - res2_next;
                res2_next = res2_next & x1_item_reg.mask;
            end
            OP_CMP:
            begin
                if (x1_item_reg.sgn)
                    less2_next = $signed(x1_item_reg.xa) < $signed(x1_item_reg.xb);
                else
                    less2_next = x1_item_reg.xa < x1_item_reg.xb;
                equal2_next = x1_item_reg.xa == x1_item_reg.xb;
            end
            default: res2_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x2_valid_reg <= 1'b0;
        end
        else if (x2_ready)
        begin
            x2_valid_reg <= x1_adv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (x1_adv)
        begin
            x2_item_reg <= x1_item_reg;
            prod_reg    <= prod_next;
            n_reg       <= n_next;
            res2_reg    <= res2_next;
            less2_reg   <= less2_next;
            equal2_reg  <= equal2_next;
            dz2_reg     <= dz1_reg;
        end
    end

    // Stage 3 next values.
    always_comb
    begin
        ph0       = n_reg[HALF_W-1:0] * x2_item_reg.b[DATA_W-1:HALF_W];
        ph1       = n_reg[DATA_W-1:HALF_W] * x2_item_reg.b[HALF_W-1:0];
        p0_next   = n_reg[HALF_W-1:0] * x2_item_reg.b[HALF_W-1:0];
        pmid_next = ph0[HALF_W-1:0] + ph1[HALF_W-1:0];
        if (x2_item_reg.func == OP_MUL)
            res3_next = DATA_W'(prod_reg >> x2_item_reg.frac) & x2_item_reg.mask;
        else
            res3_next = res2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x3_valid_reg <= 1'b0;
        end
        else if (x3_ready)
        begin
            x3_valid_reg <= x2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (x2_valid_reg && x3_ready)
        begin
            x3_item_reg <= x2_item_reg;
            p0_reg      <= p0_next;
            pmid_reg    <= pmid_next;
            res3_reg    <= res3_next;
            less3_reg   <= less2_reg;
            equal3_reg  <= equal2_reg;
            dz3_reg     <= dz2_reg;
        end
    end

    // Output register next value: remainder fix-up.
    always_comb
    begin
        z     = (p0_reg + {pmid_reg, {HALF_W{1'b0}}}) & x3_item_reg.mask;
        zn    = x3_item_reg.sgn && z[x3_item_reg.msb];
        z_fix = (zn != x3_item_reg.na) ? ((DATA_W'(0) - z) & x3_item_reg.mask) : z;
        if ((x3_item_reg.func == OP_REM) && !dz3_reg)
            res_next = (x3_item_reg.a - z_fix) & x3_item_reg.mask;
        else
            res_next = res3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= x3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (x3_valid_reg && o_ready)
        begin
            res_reg   <= res_next;
            less_reg  <= less3_reg;
            equal_reg <= equal3_reg;
            dz_reg    <= dz3_reg;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - DATA_W - 3){1'b0}}, dz_reg, equal_reg, less_reg,
                            res_reg};

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DIV_STEPS))
        else $error("divider step count out of range");

    a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (x1_valid_reg && (cnt_reg != '0)) |-> !item_ready)
        else $error("stage 1 released while the divider is running");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && dz_reg) |-> (res_reg == '0))
        else $error("division by zero with a nonzero result");

    a_cmp_flags: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> !(less_reg && equal_reg))
        else $error("less and equal both set");

endmodule

// File: rtl/fixed_point_alu.sv
// Path: input register, item queue, stages 1 to 3, output register. Divide and
// remainder hold the execution pipeline while the restoring divider of stage 1
// makes one quotient bit per cycle. Throughput: one beat per cycle for all other
// operations while the output is ready and no divide or remainder holds stage 1.
// Reset: asynchronous, active low; clears all valid flags and loads the format
// registers with 32 total bits, 16 integer bits, two's complement.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [FMT_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // func, operand_a, operand_b, dest_width, dest_integer_bits, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // result, less, equal, div_by_zero, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic  fq_valid, fq_ready, qb_valid, qb_ready;
    item_t fq_item, qb_item;

    fpa_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .item_valid    (fq_valid),
        .item_ready    (fq_ready),
        .item          (fq_item)
    );

    fpa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    fpa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (qb_valid),
        .item_ready    (qb_ready),
        .item          (qb_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
